// ===== rtl/pse_pkg.sv =====
package pse_pkg;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_CONST = 2'd1;
	localparam logic [1:0] ST_NOINV = 2'd2;

	localparam logic REG_MODULUS       = 1'b0;
	localparam logic REG_SERIES_LENGTH = 1'b1;

	typedef struct packed {
		logic start;
		logic mul;
	} unit_cmd_t;

endpackage

// ===== rtl/pse_unit.sv =====
// Shared bit-serial unit: restoring divide (one quotient bit a cycle) or
// modular multiply (double, then conditional add, one step a cycle).
module pse_unit #(
	parameter int CB = 64,
	parameter int DW = CB + 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pse_pkg::unit_cmd_t cmd,
	input  logic [DW-1:0]      op_x,
	input  logic [CB-1:0]      op_a,
	input  logic [CB-1:0]      op_d,
	output logic               done,
	output logic [CB-1:0]      quot,
	output logic [CB-1:0]      rem
);

	localparam int NW = $clog2(DW);

	logic [CB:0]   acc_q;
	logic [DW-1:0] sh_q;
	logic [CB-1:0] d_q;
	logic [CB-1:0] a_q;
	logic [NW-1:0] cnt_q;
	logic          ph_q;
	logic          mul_q;
	logic          busy_q;
	logic          done_q;

	logic [CB:0] t;
	logic [CB:0] red;
	logic        ge;
	logic        last_step;

	always_comb begin
		if (!mul_q) begin
			t = {acc_q[CB-1:0], sh_q[DW-1]};
		end else if (ph_q) begin
			t = acc_q + (sh_q[DW-1] ? {1'b0, a_q} : '0);
		end else begin
			t = {acc_q[CB-1:0], 1'b0};
		end
		ge  = t >= {1'b0, d_q};
		red = ge ? t - {1'b0, d_q} : t;
		last_step = mul_q ? (ph_q && cnt_q == NW'(CB - 1)) : (cnt_q == NW'(DW - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			ph_q   <= 1'b0;
			mul_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				mul_q  <= cmd.mul;
				cnt_q  <= '0;
				ph_q   <= 1'b0;
			end else if (busy_q) begin
				if (mul_q) begin
					ph_q <= ~ph_q;
				end
				if (!mul_q || ph_q) begin
					cnt_q <= cnt_q + NW'(1);
				end
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
			d_q   <= op_d;
			a_q   <= op_a;
			sh_q  <= cmd.mul ? {op_x[CB-1:0], 8'h00} : op_x;
		end else if (busy_q) begin
			acc_q <= red;
			if (!mul_q) begin
				sh_q <= {sh_q[DW-2:0], ge};
			end else if (ph_q) begin
				sh_q <= {sh_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = sh_q[CB-1:0];
	assign rem  = acc_q[CB-1:0];

endmodule

// ===== rtl/power_series_exp_mod_n.sv =====
// Load: an item with a stored term is reduced mod m; items past the table are dropped.
// Series: weights first, then per k=2..n-1 a sum of products, reductions mod k, a search
// and a divide, all on the shared unit. Results pass through S_EMIT, S_ELD and S_OUT.
// in_ready is low from acceptance of a closing item until the last result transfer.
// arst_n clears the sequencer, counters and flags; modulus resets to 2, length to 1.
// The term stores are not cleared; every entry is written before it is read.
module power_series_exp_mod_n #(
	parameter int MAX_TERMS  = 64,
	parameter int COEFF_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COEFF_BITS-1:0] coefficient,
	input  logic                  last_term,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COEFF_BITS-1:0] result_coefficient,
	output logic [5:0]            result_index,
	output logic                  last_result,
	output logic [1:0]            status,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [COEFF_BITS-1:0] cfg_data
);

	localparam int CB = COEFF_BITS;
	localparam int DW = CB + 8;
	localparam int IW = $clog2(MAX_TERMS);
	localparam int CW = $clog2(MAX_TERMS + 1);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_LRED  = 5'd1;
	localparam logic [4:0] S_BEGIN = 5'd2;
	localparam logic [4:0] S_F1    = 5'd3;
	localparam logic [4:0] S_WRD   = 5'd4;
	localparam logic [4:0] S_WST   = 5'd5;
	localparam logic [4:0] S_WRUN  = 5'd6;
	localparam logic [4:0] S_KCHK  = 5'd7;
	localparam logic [4:0] S_SRD   = 5'd8;
	localparam logic [4:0] S_SST   = 5'd9;
	localparam logic [4:0] S_SRUN  = 5'd10;
	localparam logic [4:0] S_MKST  = 5'd11;
	localparam logic [4:0] S_MKRUN = 5'd12;
	localparam logic [4:0] S_SKST  = 5'd13;
	localparam logic [4:0] S_SKRUN = 5'd14;
	localparam logic [4:0] S_TSRCH = 5'd15;
	localparam logic [4:0] S_QRUN  = 5'd16;
	localparam logic [4:0] S_EMIT  = 5'd17;
	localparam logic [4:0] S_ELD   = 5'd18;
	localparam logic [4:0] S_OUT   = 5'd19;

	logic [4:0]    state_q;
	logic [CB-1:0] mod_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] hlen_q;
	logic [CW-1:0] hl_q;
	logic          cnz_q;
	logic          last_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] lim_q;
	logic [CW-1:0] l_q;
	logic [IW-1:0] j_q;
	logic [IW-1:0] e_q;
	logic [IW-1:0] lastnz_q;
	logic [CB-1:0] s_q;
	logic [CW-1:0] mk_q;
	logic [CW-1:0] r1_q;
	logic [CW-1:0] r2_q;
	logic [IW-1:0] t_q;
	logic [IW-1:0] tsel_q;
	logic          ok_q;
	logic          err_q;

	logic          ov_q;
	logic [CB-1:0] oc_q;
	logic [5:0]    oi_q;
	logic          ol_q;
	logic [1:0]    os_q;

	logic [CB-1:0] h_mem [MAX_TERMS];
	logic [CB-1:0] w_mem [MAX_TERMS];
	logic [CB-1:0] f_mem [MAX_TERMS];
	logic [CB-1:0] h_rd;
	logic [CB-1:0] w_rd;
	logic [CB-1:0] f_rd;
	logic [IW-1:0] h_ra;
	logic [IW-1:0] w_ra;
	logic [IW-1:0] f_ra;
	logic          h_we;
	logic          w_we;
	logic          f_we;
	logic [IW-1:0] h_wa;
	logic [IW-1:0] w_wa;
	logic [IW-1:0] f_wa;
	logic [CB-1:0] f_wd;

	pse_pkg::unit_cmd_t u_cmd;
	logic [DW-1:0] u_x;
	logic [CB-1:0] u_a;
	logic [CB-1:0] u_d;
	logic          u_done;
	logic [CB-1:0] u_quot;
	logic [CB-1:0] u_rem;

	logic          in_xfer;
	logic [CB:0]   ssum;
	logic [CB-1:0] s_next;
	logic [CW:0]   r1_sum;
	logic [CW:0]   r2_sum;
	logic [CW-1:0] r1_next;
	logic [CW-1:0] r2_next;
	logic          ok_n;
	logic [IW-1:0] tsel_n;
	logic          t_end;
	logic [CB+IW-1:0] tm;
	logic [CB+CW-1:0] kh;
	logic [6:0]    len_in;

	assign in_ready = state_q == S_IDLE;
	assign in_xfer  = in_valid && in_ready;

	assign ssum    = {1'b0, s_q} + {1'b0, u_rem};
	assign s_next  = (ssum >= {1'b0, mod_q}) ? CB'(ssum - {1'b0, mod_q}) : ssum[CB-1:0];
	assign r1_sum  = {1'b0, r1_q} + {1'b0, mk_q};
	assign r2_sum  = {1'b0, r2_q} + {1'b0, mk_q};
	assign r1_next = (r1_sum >= {1'b0, k_q}) ? CW'(r1_sum - {1'b0, k_q}) : r1_sum[CW-1:0];
	assign r2_next = (r2_sum >= {1'b0, k_q}) ? CW'(r2_sum - {1'b0, k_q}) : r2_sum[CW-1:0];
	assign ok_n    = ok_q || (r1_q == '0);
	assign tsel_n  = (r2_q == '0) ? t_q : tsel_q;
	assign t_end   = t_q == IW'(k_q - CW'(1));
	assign tm      = (CB+IW)'(mod_q) * (CB+IW)'(tsel_n);
	assign kh      = (CB+CW)'(h_rd) * (CB+CW)'(k_q);
	assign len_in  = cfg_data[6:0];

	pse_unit #(.CB(CB), .DW(DW)) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (u_cmd),
		.op_x   (u_x),
		.op_a   (u_a),
		.op_d   (u_d),
		.done   (u_done),
		.quot   (u_quot),
		.rem    (u_rem)
	);

	always_comb begin
		u_cmd = '0;
		u_x   = DW'(coefficient);
		u_a   = w_rd;
		u_d   = mod_q;
		unique case (state_q)
			S_IDLE: begin
				u_cmd.start = in_xfer && (cnt_q < CW'(MAX_TERMS));
			end
			S_WST: begin
				u_cmd.start = 1'b1;
				u_x = DW'(kh);
			end
			S_SST: begin
				u_cmd.start = 1'b1;
				u_cmd.mul   = 1'b1;
				u_x = DW'(f_rd);
			end
			S_MKST: begin
				u_cmd.start = 1'b1;
				u_x = DW'(mod_q);
				u_d = CB'(k_q);
			end
			S_SKST: begin
				u_cmd.start = 1'b1;
				u_x = DW'(s_q);
				u_d = CB'(k_q);
			end
			S_TSRCH: begin
				u_cmd.start = t_end && ok_n;
				u_x = DW'(s_q) + DW'(tm);
				u_d = CB'(k_q);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		h_ra = (state_q == S_BEGIN) ? IW'(1) : k_q[IW-1:0];
		w_ra = IW'(j_q + IW'(1));
		f_ra = (state_q == S_SRD) ? IW'(k_q - CW'(1) - CW'(j_q)) : e_q;
		h_we = (state_q == S_LRED) && u_done;
		h_wa = cnt_q[IW-1:0];
		w_we = (state_q == S_WRUN) && u_done;
		w_wa = k_q[IW-1:0];
		f_we = 1'b0;
		f_wa = k_q[IW-1:0];
		f_wd = u_quot;
		if (state_q == S_BEGIN) begin
			f_we = !cnz_q;
			f_wa = '0;
			f_wd = CB'(1);
		end else if (state_q == S_F1) begin
			f_we = 1'b1;
			f_wa = IW'(1);
			f_wd = h_rd;
		end else if (state_q == S_QRUN) begin
			f_we = u_done;
		end
	end

	always_ff @(posedge clk) begin
		if (h_we) begin
			h_mem[h_wa] <= u_rem;
		end
		h_rd <= h_mem[h_ra];
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			w_mem[w_wa] <= u_rem;
		end
		w_rd <= w_mem[w_ra];
	end

	always_ff @(posedge clk) begin
		if (f_we) begin
			f_mem[f_wa] <= f_wd;
		end
		f_rd <= f_mem[f_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= CB'(2);
			n_q   <= CW'(1);
		end else if (cfg_we) begin
			if (cfg_index == pse_pkg::REG_MODULUS) begin
				mod_q <= (cfg_data < CB'(2)) ? CB'(2) : cfg_data;
			end else begin
				if (len_in == 7'd0) begin
					n_q <= CW'(1);
				end else if (32'(len_in) > MAX_TERMS) begin
					n_q <= CW'(MAX_TERMS);
				end else begin
					n_q <= CW'(len_in);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			hlen_q  <= '0;
			cnz_q   <= 1'b0;
			last_q  <= 1'b0;
			ov_q    <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						last_q <= last_term;
						if (cnt_q < CW'(MAX_TERMS)) begin
							state_q <= S_LRED;
						end else if (last_term) begin
							state_q <= S_BEGIN;
						end
					end
				end
				S_LRED: begin
					if (u_done) begin
						if (u_rem != '0) begin
							hlen_q <= cnt_q + CW'(1);
							if (cnt_q == '0) begin
								cnz_q <= 1'b1;
							end
						end
						cnt_q   <= cnt_q + CW'(1);
						state_q <= last_q ? S_BEGIN : S_IDLE;
					end
				end
				S_BEGIN: begin
					cnt_q  <= '0;
					cnz_q  <= 1'b0;
					hlen_q <= '0;
					hl_q   <= hlen_q;
					e_q    <= '0;
					lastnz_q <= '0;
					if (cnz_q) begin
						err_q   <= 1'b1;
						ov_q    <= 1'b1;
						oc_q    <= '0;
						oi_q    <= '0;
						ol_q    <= 1'b1;
						os_q    <= pse_pkg::ST_CONST;
						state_q <= S_OUT;
					end else begin
						err_q <= 1'b0;
						if (hlen_q >= CW'(2) && n_q >= CW'(2)) begin
							state_q <= S_F1;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_F1: begin
					if (h_rd != '0) begin
						lastnz_q <= IW'(1);
					end
					k_q     <= CW'(1);
					lim_q   <= (n_q < hl_q) ? n_q : hl_q;
					state_q <= S_WRD;
				end
				S_WRD: begin
					state_q <= S_WST;
				end
				S_WST: begin
					state_q <= S_WRUN;
				end
				S_WRUN: begin
					if (u_done) begin
						if (k_q + CW'(1) < lim_q) begin
							k_q     <= k_q + CW'(1);
							state_q <= S_WRD;
						end else begin
							k_q     <= CW'(2);
							state_q <= S_KCHK;
						end
					end
				end
				S_KCHK: begin
					if (k_q >= n_q) begin
						state_q <= S_EMIT;
					end else begin
						s_q     <= '0;
						j_q     <= '0;
						l_q     <= (k_q < hl_q - CW'(1)) ? k_q : hl_q - CW'(1);
						state_q <= S_SRD;
					end
				end
				S_SRD: begin
					state_q <= S_SST;
				end
				S_SST: begin
					state_q <= S_SRUN;
				end
				S_SRUN: begin
					if (u_done) begin
						s_q <= s_next;
						if (CW'(j_q) + CW'(1) < l_q) begin
							j_q     <= j_q + IW'(1);
							state_q <= S_SRD;
						end else begin
							state_q <= S_MKST;
						end
					end
				end
				S_MKST: begin
					state_q <= S_MKRUN;
				end
				S_MKRUN: begin
					if (u_done) begin
						mk_q    <= u_rem[CW-1:0];
						state_q <= S_SKST;
					end
				end
				S_SKST: begin
					state_q <= S_SKRUN;
				end
				S_SKRUN: begin
					if (u_done) begin
						r1_q    <= CW'(1);
						r2_q    <= u_rem[CW-1:0];
						t_q     <= '0;
						ok_q    <= 1'b0;
						state_q <= S_TSRCH;
					end
				end
				S_TSRCH: begin
					ok_q   <= ok_n;
					tsel_q <= tsel_n;
					r1_q   <= r1_next;
					r2_q   <= r2_next;
					t_q    <= t_q + IW'(1);
					if (t_end) begin
						if (ok_n) begin
							state_q <= S_QRUN;
						end else begin
							err_q   <= 1'b1;
							ov_q    <= 1'b1;
							oc_q    <= '0;
							oi_q    <= '0;
							ol_q    <= 1'b1;
							os_q    <= pse_pkg::ST_NOINV;
							state_q <= S_OUT;
						end
					end
				end
				S_QRUN: begin
					if (u_done) begin
						if (u_quot != '0) begin
							lastnz_q <= k_q[IW-1:0];
						end
						k_q     <= k_q + CW'(1);
						state_q <= S_KCHK;
					end
				end
				S_EMIT: begin
					state_q <= S_ELD;
				end
				S_ELD: begin
					ov_q    <= 1'b1;
					oc_q    <= f_rd;
					oi_q    <= 6'(e_q);
					ol_q    <= e_q == lastnz_q;
					os_q    <= pse_pkg::ST_OK;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						ov_q <= 1'b0;
						if (err_q || ol_q) begin
							state_q <= S_IDLE;
						end else begin
							e_q     <= e_q + IW'(1);
							state_q <= S_EMIT;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid          = ov_q;
	assign result_coefficient = oc_q;
	assign result_index       = oi_q;
	assign last_result        = ol_q;
	assign status             = os_q;

endmodule

// ===== rtl/pse_chk.sv =====
module pse_chk #(
	parameter int COEFF_BITS = 64
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COEFF_BITS-1:0] result_coefficient,
	input logic [5:0]            result_index,
	input logic                  last_result,
	input logic [1:0]            status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_coefficient)
			&& $stable(result_index) && $stable(status))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != pse_pkg::ST_OK |-> last_result
			&& result_coefficient == '0 && result_index == 6'd0)
		else $error("malformed error result");

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pse_pkg::ST_OK && result_index == 6'd0
			|-> result_coefficient == COEFF_BITS'(1))
		else $error("constant term of exp not one");

endmodule

bind power_series_exp_mod_n pse_chk #(.COEFF_BITS(COEFF_BITS)) u_pse_chk (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_ready           (in_ready),
	.out_valid          (out_valid),
	.out_ready          (out_ready),
	.result_coefficient (result_coefficient),
	.result_index       (result_index),
	.last_result        (last_result),
	.status             (status)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam logic [63:0] BIG_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;
	localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [63:0] coef;
		logic [5:0]  idx;
		logic        last;
		logic [1:0]  st;
	} exp_term_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] coefficient;
	logic        last_term;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] result_coefficient;
	logic [5:0]  result_index;
	logic        last_result;
	logic [1:0]  status;
	logic        cfg_we;
	logic        cfg_index;
	logic [63:0] cfg_data;

	exp_term_t   expected_terms[$];
	int          errors;
	int          items_sent;
	int          sets_sent;
	int          results_seen;
	int          hold_len;
	bit          idle_on;

	// predictor state
	logic [63:0] mod_reg;
	logic [6:0]  len_reg;
	logic [63:0] h_terms[64];
	int          loaded;
	bit          const_nz;

	power_series_exp_mod_n u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.coefficient(coefficient), .last_term(last_term),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_coefficient(result_coefficient), .result_index(result_index),
		.last_result(last_result), .status(status),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [63:0] add_m(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m})
			s = s - {1'b0, m};
		return s[63:0];
	endfunction

	function automatic logic [63:0] sub_m(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		return (a >= b) ? a - b : a + (m - b);
	endfunction

	function automatic logic [63:0] mul_m(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p % {64'd0, m};
		return p[63:0];
	endfunction

	function automatic bit inv_m(logic [63:0] a, logic [63:0] m, output logic [63:0] r);
		logic [63:0] r0, r1, r2, t0, t1, t2, q;
		r0 = m;
		r1 = a;
		t0 = 0;
		t1 = 64'd1 % m;
		r = 0;
		while (r1 != 0) begin
			q = r0 / r1;
			r2 = r0 - q * r1;
			t2 = sub_m(t0, mul_m(q % m, t1, m), m);
			r0 = r1;
			r1 = r2;
			t0 = t1;
			t1 = t2;
		end
		if (r0 != 1)
			return 0;
		r = t0;
		return 1;
	endfunction

	function automatic void push_term(logic [63:0] c, int k, bit l, logic [1:0] st);
		exp_term_t e;
		e.coef = c;
		e.idx = k[5:0];
		e.last = l;
		e.st = st;
		expected_terms.push_back(e);
	endfunction

	// feeds one accepted item to the predictor; a closing item queues the series
	function automatic void predict_exp(logic [63:0] c_in, bit fin);
		logic [63:0] m, c, s, iv;
		logic [63:0] f[64];
		logic [63:0] w[64];
		int n, hlen, lim, top, l;
		m = (mod_reg < 2) ? 64'd2 : mod_reg;
		c = c_in % m;
		if (loaded < 64) begin
			if (loaded == 0 && c != 0)
				const_nz = 1;
			h_terms[loaded] = c;
			loaded++;
		end
		if (!fin)
			return;
		n = (len_reg == 0) ? 1 : (len_reg > 64) ? 64 : len_reg;
		hlen = loaded;
		while (hlen > 0 && h_terms[hlen-1] == 0)
			hlen--;
		loaded = 0;
		if (const_nz) begin
			const_nz = 0;
			push_term(0, 0, 1, pse_pkg::ST_CONST);
			return;
		end
		f[0] = 1;
		top = 0;
		if (hlen >= 2 && n >= 2) begin
			f[1] = h_terms[1];
			lim = (n < hlen) ? n : hlen;
			for (int k = 1; k < lim; k++)
				w[k] = mul_m(h_terms[k], 64'(k) % m, m);
			for (int k = 2; k < n; k++) begin
				s = 0;
				l = (k < hlen - 1) ? k : hlen - 1;
				for (int j = 0; j < l; j++)
					s = add_m(s, mul_m(w[1+j], f[k-1-j], m), m);
				if (!inv_m(64'(k) % m, m, iv)) begin
					push_term(0, 0, 1, pse_pkg::ST_NOINV);
					return;
				end
				f[k] = mul_m(s, iv, m);
			end
			for (int k = 0; k < n; k++)
				if (f[k] != 0)
					top = k;
		end
		for (int k = 0; k <= top; k++)
			push_term(f[k], k, k == top, pse_pkg::ST_OK);
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
			results_seen);
	endtask

	always @(posedge clk) begin
		exp_term_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_terms.size() == 0) begin
				report("unexpected result", result_coefficient, 0);
			end else begin
				e = expected_terms.pop_front();
				if (result_coefficient !== e.coef)
					report("coefficient", result_coefficient, e.coef);
				if (result_index !== e.idx)
					report("index", result_index, e.idx);
				if (last_result !== e.last)
					report("last_result", last_result, e.last);
				if (status !== e.st)
					report("status", status, e.st);
			end
		end
	end

	// receiver: random stalls after transfers while idle_on is set, plus an optional long hold
	initial begin
		int d;
		forever begin
			@(posedge clk);
			d = 0;
			if (hold_len > 0) begin
				d = hold_len;
				hold_len = 0;
			end else if (out_valid && out_ready && idle_on) begin
				d = $urandom_range(0, 19);
			end
			if (d > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (d) @(negedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_term(logic [63:0] c, bit fin);
		int gap;
		gap = idle_on ? $urandom_range(0, 19) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		coefficient <= c;
		last_term <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		predict_exp(c, fin);
		if (fin)
			sets_sent++;
	endtask

	task automatic send_set(logic [63:0] terms[$]);
		foreach (terms[i])
			send_term(terms[i], i == terms.size() - 1);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_terms.size() != 0 || !in_ready)
			@(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == pse_pkg::REG_MODULUS)
			mod_reg = val;
		else
			len_reg = val[6:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(logic [63:0] m, logic [63:0] n);
		settle();
		write_reg(pse_pkg::REG_MODULUS, m);
		write_reg(pse_pkg::REG_SERIES_LENGTH, n);
	endtask

	task automatic test_reset_defaults();
		send_set('{64'd0, 64'd1});
		send_set('{64'd0});
	endtask

	task automatic test_error_cases();
		configure(64'd97, 64'd6);
		send_set('{64'd5, 64'd1, 64'd2});
		send_set('{64'd97, 64'd3, 64'd1});
		configure(64'd6, 64'd4);
		send_set('{64'd0, 64'd1});
		send_set('{64'd1, 64'd1});
		send_set('{64'd0, 64'd0});
	endtask

	task automatic test_register_extremes();
		configure(64'd0, 64'd0);
		send_set('{64'd0, 64'd1});
		configure(64'd1, 64'd3);
		send_set('{64'd0, ALL_ONES, 64'd0});
		configure(ALL_ONES, 64'd127);
		send_set('{ALL_ONES, 64'd0, 64'd0, ALL_ONES - 1});
		configure(BIG_PRIME, 64'd5);
		send_set('{64'd0, BIG_PRIME - 1, 64'd0, 64'd0});
		send_set('{64'd0, 64'd0, 64'd7});
	endtask

	// a long set past the table size at full length; once its results start the
	// receiver is held off while the next set waits at the input
	task automatic test_full_table();
		logic [63:0] terms[$];
		configure(BIG_PRIME, 64'd64);
		terms.push_back(64'd0);
		for (int i = 1; i < 66; i++)
			terms.push_back({$urandom, $urandom});
		send_set(terms);
		wait (out_valid);
		hold_len = 400;
		send_set('{64'd0, 64'd3});
	endtask

	task automatic test_random_sets();
		logic [63:0] terms[$];
		logic [63:0] m;
		int len, r;
		while (items_sent < 410) begin
			r = $urandom_range(0, 5);
			case (r)
				0: m = BIG_PRIME;
				1: m = ALL_ONES;
				2: m = $urandom_range(2, 1000);
				3: m = 64'd65537;
				default: m = {$urandom, $urandom};
			endcase
			configure(m, $urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
				: $urandom_range(1, 10));
			idle_on = ($urandom_range(0, 3) != 0);
			repeat (12) begin
				if (items_sent >= 410)
					break;
				terms.delete();
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					r = $urandom_range(0, 9);
					if (i == 0)
						terms.push_back(r == 0 ? {$urandom, $urandom} : 64'd0);
					else if (r < 2)
						terms.push_back(64'd0);
					else if (r < 5)
						terms.push_back({$urandom, $urandom});
					else
						terms.push_back({$urandom, $urandom} % m);
				end
				if ($urandom_range(0, 9) == 0) begin
					// noise: an item without a closing flag before the set
					send_term({$urandom, $urandom}, 1'b0);
				end
				send_set(terms);
			end
		end
	endtask

	initial begin
		errors = 0;
		items_sent = 0;
		sets_sent = 0;
		results_seen = 0;
		hold_len = 0;
		idle_on = 1;
		mod_reg = 2;
		len_reg = 1;
		loaded = 0;
		const_nz = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		coefficient = '0;
		last_term = 1'b0;
		out_ready = 1'b1;
		cfg_we = 1'b0;
		cfg_index = pse_pkg::REG_MODULUS;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_error_cases();
		test_register_extremes();
		test_full_table();
		test_random_sets();

		settle();
		$display("covered %0d items in %0d sets, %0d result transfers checked", items_sent,
			sets_sent, results_seen);
		$display("error cases, register extremes, overlong set and receiver hold included");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#1_000_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== power_series_exp_mod_n.f =====
rtl/pse_pkg.sv
rtl/pse_unit.sv
rtl/power_series_exp_mod_n.sv
rtl/pse_chk.sv
bench/testbench.sv
